>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
// every macro samples on the rising edge of clk and is held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check: when ante holds, cons must hold in the same cycle
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle check: when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/rci_pkg.sv
`default_nettype none

package rci_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;

  // multiplier pipeline depth
  localparam int MUL_LAT = 4;

  // square root: one result bit per stage, radicand is the 63-bit
  // non-negative discriminant shifted up by the fraction bits
  localparam int SQRT_STEPS = (63 + FRAC_BITS + 1) / 2;
  localparam int SQRT_LAT = SQRT_STEPS + 1;

  // divider: one quotient bit per stage over the shifted dividend
  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int DIV_LAT = DIV_STEPS + 2;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  // magnitude of a signed 64-bit value as unsigned
  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  // sign and magnitude back to saturated signed 64-bit
  function automatic logic signed [63:0] to_sat(input logic neg, input logic hi_nz,
                                                input logic [63:0] lo);
    if (neg) begin
      if (hi_nz || lo[63]) begin
        to_sat = S64_MIN;
      end else begin
        to_sat = 64'd0 - lo;
      end
    end else begin
      if (hi_nz || lo[63]) begin
        to_sat = S64_MAX;
      end else begin
        to_sat = lo;
      end
    end
  endfunction

  // saturating add
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sadd = s[64] ? S64_MIN : S64_MAX;
    end else begin
      sadd = s[63:0];
    end
  endfunction

  // saturating subtract
  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      ssub = s[64] ? S64_MIN : S64_MAX;
    end else begin
      ssub = s[63:0];
    end
  endfunction

  // halve with truncation toward zero
  function automatic logic signed [63:0] half_tz(input logic signed [63:0] x);
    logic signed [63:0] adj;
    adj = x + {63'd0, x[63]};
    half_tz = adj >>> 1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ray_cylinder_intersect.sv
`default_nettype none
// Ray against infinite cylinder intersection, signed Q16.16 throughout.
// Input channel: drive the ray direction, unit axis, origin offset, squared
// radius, distance limit and near_first, and raise start; the item transfers
// at the rising edge where start is high and busy is low. busy never rises,
// so a new item may transfer on every cycle.
// Result channel: done is high for exactly one cycle with hit and distance
// valid in that cycle; distance is 0 when hit is 0. The receiver cannot
// stall the block, results appear in transfer order, one per item.
// Each item passes in order through the dot-product and coefficient
// multipliers (4-stage 64x64 units, three deep in series), the 40-stage
// square root and the 80-step divider pair that forms both roots.
// Throughput: one item per cycle.
// Reset: rst synchronously clears the valid pipeline, so no done pulse
// appears for items in flight at reset; datapath registers are not cleared.
`include "assert_macros.svh"

module ray_cylinder_intersect (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic signed [31:0] dir_z,
  input  wire logic signed [31:0] axis_x,
  input  wire logic signed [31:0] axis_y,
  input  wire logic signed [31:0] axis_z,
  input  wire logic signed [31:0] rel_x,
  input  wire logic signed [31:0] rel_y,
  input  wire logic signed [31:0] rel_z,
  input  wire logic [30:0]        radius_sq,
  input  wire logic [30:0]        t_limit,
  input  wire logic               near_first,
  output logic                    done,
  output logic                    hit,
  output logic [30:0]             distance
);

  // edge at which each stage's registers hold the item
  localparam int E_DOT  = rci_pkg::MUL_LAT + 1;
  localparam int E_M2   = E_DOT + rci_pkg::MUL_LAT;
  localparam int E_ABC0 = E_M2 + 1;
  localparam int E_ABC  = E_ABC0 + 1;
  localparam int E_M3   = E_ABC + rci_pkg::MUL_LAT;
  localparam int E_AC4  = E_M3 + 1;
  localparam int E_DISC = E_AC4 + 1;
  localparam int E_SQ   = E_DISC + rci_pkg::SQRT_LAT;
  localparam int E_SUM  = E_SQ + 1;
  localparam int E_Q    = E_SUM + 1;
  localparam int E_DIV  = E_Q + rci_pkg::DIV_LAT;
  localparam int E_ORD  = E_DIV + 1;
  localparam int E_OUT  = E_ORD + 1;
  localparam int ABC_LEN = E_DISC - E_ABC;
  localparam int NMUL = 20;

  typedef struct packed {
    logic [30:0] radius_sq;
    logic [30:0] t_limit;
    logic        near_first;
  } side_t;

  typedef struct packed {
    logic signed [63:0] vv;
    logic signed [63:0] vw;
    logic signed [63:0] ww;
  } dots_t;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] c;
  } abc_t;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] c;
    logic               dz;
    logic               nohit;
  } st_t;

  typedef struct packed {
    logic dz;
    logic nohit;
  } fl_t;

  logic               vld [E_OUT];
  side_t              sd  [E_ORD];
  logic signed [63:0] mul_a [NMUL];
  logic signed [63:0] mul_b [NMUL];
  logic signed [63:0] mul_p [NMUL];
  logic signed [63:0] vh, wh, vv, vw, ww;
  dots_t              dd  [rci_pkg::MUL_LAT];
  logic signed [63:0] a0, b0, c0, a1, b1, c1;
  abc_t               abc [ABC_LEN];
  logic signed [63:0] ac4, bb, disc;
  st_t                st  [rci_pkg::SQRT_LAT];
  logic [rci_pkg::SQRT_STEPS-1:0] root;
  st_t                sm;
  logic signed [63:0] sum;
  logic signed [63:0] n1, a2, c2, qv;
  fl_t                fq;
  fl_t                fl  [rci_pkg::DIV_LAT];
  logic signed [63:0] t1d, t2d;
  logic signed [63:0] t1o, t2o;
  logic               nohit_o;
  logic signed [63:0] s64;
  logic signed [63:0] half_sum;
  logic signed [63:0] t2sel;
  logic               swap;
  logic signed [63:0] lim64;
  logic signed [63:0] tsel;
  logic               miss;

  // no backpressure: every item flows straight through
  assign busy = 1'b0;

  // valid and side-data pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < E_OUT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= start & ~busy;
      for (int i = 1; i < E_OUT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= '{radius_sq: radius_sq, t_limit: t_limit, near_first: near_first};
    for (int i = 1; i < E_ORD; i++) begin
      sd[i] <= sd[i-1];
    end
  end

  // multiplier operand routing: dot terms, then coefficient products
  always_comb begin
    mul_a[0]  = 64'(dir_x);  mul_b[0]  = 64'(axis_x);
    mul_a[1]  = 64'(dir_y);  mul_b[1]  = 64'(axis_y);
    mul_a[2]  = 64'(dir_z);  mul_b[2]  = 64'(axis_z);
    mul_a[3]  = 64'(rel_x);  mul_b[3]  = 64'(axis_x);
    mul_a[4]  = 64'(rel_y);  mul_b[4]  = 64'(axis_y);
    mul_a[5]  = 64'(rel_z);  mul_b[5]  = 64'(axis_z);
    mul_a[6]  = 64'(dir_x);  mul_b[6]  = 64'(dir_x);
    mul_a[7]  = 64'(dir_y);  mul_b[7]  = 64'(dir_y);
    mul_a[8]  = 64'(dir_z);  mul_b[8]  = 64'(dir_z);
    mul_a[9]  = 64'(dir_x);  mul_b[9]  = 64'(rel_x);
    mul_a[10] = 64'(dir_y);  mul_b[10] = 64'(rel_y);
    mul_a[11] = 64'(dir_z);  mul_b[11] = 64'(rel_z);
    mul_a[12] = 64'(rel_x);  mul_b[12] = 64'(rel_x);
    mul_a[13] = 64'(rel_y);  mul_b[13] = 64'(rel_y);
    mul_a[14] = 64'(rel_z);  mul_b[14] = 64'(rel_z);
    mul_a[15] = vh;          mul_b[15] = vh;
    mul_a[16] = vh;          mul_b[16] = wh;
    mul_a[17] = wh;          mul_b[17] = wh;
    mul_a[18] = a1;          mul_b[18] = c1;
    mul_a[19] = b1;          mul_b[19] = b1;
  end

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    rci_fmul u_mul (
      .clk (clk),
      .x   (mul_a[i]),
      .y   (mul_b[i]),
      .p   (mul_p[i])
    );
  end

  // dot products: 32-bit operands, sums stay far from saturation
  always_ff @(posedge clk) begin
    vh <= mul_p[0] + mul_p[1] + mul_p[2];
    wh <= mul_p[3] + mul_p[4] + mul_p[5];
    vv <= mul_p[6] + mul_p[7] + mul_p[8];
    vw <= mul_p[9] + mul_p[10] + mul_p[11];
    ww <= mul_p[12] + mul_p[13] + mul_p[14];
  end

  // hold the plain dots while the axis projections are squared
  always_ff @(posedge clk) begin
    dd[0] <= '{vv: vv, vw: vw, ww: ww};
    for (int i = 1; i < rci_pkg::MUL_LAT; i++) begin
      dd[i] <= dd[i-1];
    end
  end

  // quadratic coefficients
  always_ff @(posedge clk) begin
    a0 <= rci_pkg::ssub(dd[E_M2-E_DOT-1].vv, mul_p[15]);
    b0 <= rci_pkg::ssub(dd[E_M2-E_DOT-1].vw, mul_p[16]);
    c0 <= rci_pkg::ssub(dd[E_M2-E_DOT-1].ww, mul_p[17]);
  end

  always_ff @(posedge clk) begin
    a1 <= a0;
    b1 <= rci_pkg::sadd(b0, b0);
    c1 <= rci_pkg::ssub(c0, 64'(sd[E_ABC0-1].radius_sq));
  end

  always_ff @(posedge clk) begin
    abc[0] <= '{a: a1, b: b1, c: c1};
    for (int i = 1; i < ABC_LEN; i++) begin
      abc[i] <= abc[i-1];
    end
  end

  // discriminant b*b - 4ac, each doubling saturates
  always_ff @(posedge clk) begin
    ac4 <= rci_pkg::sadd(rci_pkg::sadd(mul_p[18], mul_p[18]),
                         rci_pkg::sadd(mul_p[18], mul_p[18]));
    bb  <= mul_p[19];
  end

  always_ff @(posedge clk) begin
    disc <= rci_pkg::ssub(bb, ac4);
  end

  rci_sqrt u_sqrt (
    .clk  (clk),
    .disc (disc),
    .root (root)
  );

  // coefficients and early flags ride alongside the square root
  always_ff @(posedge clk) begin
    st[0] <= '{a: abc[ABC_LEN-1].a, b: abc[ABC_LEN-1].b, c: abc[ABC_LEN-1].c,
               dz: (disc == 64'sd0),
               nohit: disc[63] || (abc[ABC_LEN-1].a == 64'sd0)};
    for (int i = 1; i < rci_pkg::SQRT_LAT; i++) begin
      st[i] <= st[i-1];
    end
  end

  // stable root form: b + sgn(b) * sqrt(disc), with b = 0 taking the minus sign
  assign s64 = 64'(root);

  always_ff @(posedge clk) begin
    sm <= st[rci_pkg::SQRT_LAT-1];
    if ($signed(st[rci_pkg::SQRT_LAT-1].b) > 64'sd0) begin
      sum <= rci_pkg::sadd(st[rci_pkg::SQRT_LAT-1].b, s64);
    end else begin
      sum <= rci_pkg::ssub(st[rci_pkg::SQRT_LAT-1].b, s64);
    end
  end

  // q = -(sum / 2); a double root divides -(b / 2) by a instead
  assign half_sum = rci_pkg::half_tz(sum);

  always_ff @(posedge clk) begin
    a2 <= sm.a;
    c2 <= sm.c;
    qv <= 64'sd0 - half_sum;
    if (sm.dz) begin
      n1 <= 64'sd0 - rci_pkg::half_tz(sm.b);
    end else begin
      n1 <= 64'sd0 - half_sum;
    end
    fq <= '{dz: sm.dz, nohit: sm.nohit || (!sm.dz && (half_sum == 64'sd0))};
  end

  rci_div u_div_t1 (
    .clk (clk),
    .n   (n1),
    .d   (a2),
    .q   (t1d)
  );

  rci_div u_div_t2 (
    .clk (clk),
    .n   (c2),
    .d   (qv),
    .q   (t2d)
  );

  always_ff @(posedge clk) begin
    fl[0] <= fq;
    for (int i = 1; i < rci_pkg::DIV_LAT; i++) begin
      fl[i] <= fl[i-1];
    end
  end

  // root ordering
  assign t2sel = fl[rci_pkg::DIV_LAT-1].dz ? t1d : t2d;
  assign swap  = sd[E_DIV-1].near_first ? (t1d > t2sel) : (t1d < t2sel);

  always_ff @(posedge clk) begin
    t1o     <= swap ? t2sel : t1d;
    t2o     <= swap ? t1d : t2sel;
    nohit_o <= fl[rci_pkg::DIV_LAT-1].nohit;
  end

  // root choice, range checks and output saturation
  assign lim64 = 64'(sd[E_ORD-1].t_limit);
  assign tsel  = (t1o > 64'sd0) ? t1o : t2o;
  assign miss  = nohit_o || (t1o[63] && t2o[63]) || ((t1o > lim64) && (t2o > lim64))
               || (tsel <= 64'sd0);

  always_ff @(posedge clk) begin
    hit <= ~miss;
    if (miss) begin
      distance <= '0;
    end else if (tsel > 64'(rci_pkg::DIST_MAX)) begin
      distance <= rci_pkg::DIST_MAX;
    end else begin
      distance <= tsel[30:0];
    end
  end

  assign done = vld[E_OUT-1];

  `ASSERT_IMPL(a_miss_zero_dist, done && !hit, distance == '0)
  `ASSERT_IMPL(a_hit_positive, done && hit, distance != '0)
  `ASSERT_NEXT(a_start_enters, start && !busy, vld[0])

endmodule

`default_nettype wire

>>> hw/rtl/rci_fmul.sv
`default_nettype none

module rci_fmul (
  input  wire logic               clk,
  input  wire logic signed [63:0] x,
  input  wire logic signed [63:0] y,
  output logic signed [63:0]      p
);

  logic        neg1, neg2, neg3;
  logic [63:0] mx, my;
  logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [127:0] prod;
  logic [127:0] prod_sh;

  // stage 1: sign and magnitudes
  always_ff @(posedge clk) begin
    neg1 <= x[63] ^ y[63];
    mx   <= rci_pkg::mag64(x);
    my   <= rci_pkg::mag64(y);
  end

  // stage 2: four 32x32 partial products
  always_ff @(posedge clk) begin
    neg2  <= neg1;
    pp_ll <= 64'(mx[31:0]) * 64'(my[31:0]);
    pp_lh <= 64'(mx[31:0]) * 64'(my[63:32]);
    pp_hl <= 64'(mx[63:32]) * 64'(my[31:0]);
    pp_hh <= 64'(mx[63:32]) * 64'(my[63:32]);
  end

  // stage 3: full 128-bit product
  always_ff @(posedge clk) begin
    neg3 <= neg2;
    prod <= {pp_hh, 64'd0} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0}
          + {64'd0, pp_ll};
  end

  // stage 4: drop fraction bits and saturate
  assign prod_sh = prod >> rci_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    p <= rci_pkg::to_sat(neg3, |prod_sh[127:64], prod_sh[63:0]);
  end

endmodule

`default_nettype wire

>>> hw/rtl/rci_sqrt.sv
`default_nettype none

module rci_sqrt (
  input  wire logic               clk,
  input  wire logic signed [63:0] disc,
  output logic [rci_pkg::SQRT_STEPS-1:0] root
);

  localparam int STEPS = rci_pkg::SQRT_STEPS;
  localparam int RAD_W = 2 * STEPS;
  localparam int REM_W = STEPS + 2;

  logic [RAD_W-1:0] rad   [STEPS+1];
  logic [REM_W-1:0] rem   [STEPS+1];
  logic [STEPS-1:0] rt    [STEPS+1];

  // entry: clamp negative values, scale by the fraction bits
  always_ff @(posedge clk) begin
    rad[0] <= disc[63] ? '0 : RAD_W'({disc[62:0], {rci_pkg::FRAC_BITS{1'b0}}});
    rem[0] <= '0;
    rt[0]  <= '0;
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;

    assign cur   = {rem[i], rad[i][RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({rt[i], 2'b01});

    always_ff @(posedge clk) begin
      rad[i+1] <= rad[i] << 2;
      if (cur >= trial) begin
        rem[i+1] <= REM_W'(cur - trial);
        rt[i+1]  <= {rt[i][STEPS-2:0], 1'b1};
      end else begin
        rem[i+1] <= REM_W'(cur);
        rt[i+1]  <= {rt[i][STEPS-2:0], 1'b0};
      end
    end
  end

  assign root = rt[STEPS];

endmodule

`default_nettype wire

>>> hw/rtl/rci_div.sv
`default_nettype none

module rci_div (
  input  wire logic               clk,
  input  wire logic signed [63:0] n,
  input  wire logic signed [63:0] d,
  output logic signed [63:0]      q
);

  localparam int STEPS = rci_pkg::DIV_STEPS;

  logic [STEPS-1:0] nq   [STEPS+1];
  logic [63:0]      rem  [STEPS+1];
  logic [63:0]      ud   [STEPS+1];
  logic             neg  [STEPS+1];
  logic             dz   [STEPS+1];

  // entry: magnitudes, sign, scaled dividend
  always_ff @(posedge clk) begin
    nq[0]  <= {rci_pkg::mag64(n), {rci_pkg::FRAC_BITS{1'b0}}};
    rem[0] <= '0;
    ud[0]  <= rci_pkg::mag64(d);
    neg[0] <= n[63] ^ d[63];
    dz[0]  <= (d == 64'sd0);
  end

  // one quotient bit per stage, dividend bits shift out as quotient shifts in
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [64:0] sh;
    logic        ge;

    assign sh = {rem[i], nq[i][STEPS-1]};
    assign ge = (sh >= {1'b0, ud[i]});

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? 64'(sh - {1'b0, ud[i]}) : sh[63:0];
      nq[i+1]  <= {nq[i][STEPS-2:0], ge};
      ud[i+1]  <= ud[i];
      neg[i+1] <= neg[i];
      dz[i+1]  <= dz[i];
    end
  end

  // exit: apply sign and saturate, zero divisor gives zero
  always_ff @(posedge clk) begin
    if (dz[STEPS]) begin
      q <= '0;
    end else begin
      q <= rci_pkg::to_sat(neg[STEPS], |nq[STEPS][STEPS-1:64], nq[STEPS][63:0]);
    end
  end

endmodule

`default_nettype wire
